// ===== rtl/lewmv_pkg.sv =====
// Shared types, constants and helpers for the LDPC error window vote block.
// No dependencies.
package lewmv_pkg;

  localparam int WINDOW_LEN = 200;
  localparam int RECENT_LEN = 100;
  localparam int CNT_W      = $clog2(WINDOW_LEN + 1);

  localparam int ERR_W   = 8;
  localparam int LVL_W   = 3;
  localparam int WHOLE_W = 16;
  localparam int RECENT_W = 15;
  localparam int PCT_W   = 10;

  typedef enum logic {
    CMD_SAMPLE  = 1'b0,
    CMD_RESTART = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    VOTE_KEEP = 2'd0,
    VOTE_UP   = 2'd1,
    VOTE_DOWN = 2'd2
  } vote_e;

  typedef struct packed {
    logic                full;
    logic [LVL_W-1:0]    level;
    logic [WHOLE_W-1:0]  whole;
    logic [RECENT_W-1:0] newest;
  } sum_t;

  // floor(n / 3) for n below 512
  function automatic logic [PCT_W-1:0] div3(input logic [8:0] n);
    logic [16:0] prod;
    prod = n * 8'd171;
    return PCT_W'(prod[16:9]);
  endfunction

  function automatic logic up_ok(input logic [LVL_W-1:0] lvl);
    logic r;
    case (lvl)
      3'd1, 3'd2, 3'd3, 3'd4: r = 1'b1;
      default:                r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [WHOLE_W-1:0] up_limit(input logic [LVL_W-1:0] lvl);
    logic [WHOLE_W-1:0] r;
    case (lvl)
      3'd1:    r = 16'd960;
      3'd2:    r = 16'd1280;
      3'd3:    r = 16'd1280;
      3'd4:    r = 16'd5;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic down_ok(input logic [LVL_W-1:0] lvl);
    logic r;
    case (lvl)
      3'd1, 3'd2, 3'd3, 3'd4, 3'd5: r = 1'b1;
      default:                      r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [RECENT_W-1:0] down_limit(input logic [LVL_W-1:0] lvl);
    logic [RECENT_W-1:0] r;
    case (lvl)
      3'd1:    r = 15'd2240;
      3'd2:    r = 15'd2880;
      3'd3:    r = 15'd5120;
      3'd4:    r = 15'd5760;
      3'd5:    r = 15'd4800;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/lewmv_cell.sv =====
// One stage of the error count shift line.
// Depends on lewmv_pkg.
module lewmv_cell (
  input  logic                       clk_i,
  input  logic                       shift_i,
  input  logic [lewmv_pkg::ERR_W-1:0] data_i,
  output logic [lewmv_pkg::ERR_W-1:0] data_o
);
  import lewmv_pkg::*;

  logic [ERR_W-1:0] data_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= data_i;
    end
  end

  assign data_o = data_q;

endmodule

// ===== rtl/lewmv_window.sv =====
// Window of error counts as a row of cells, fill counter and running sums.
// Depends on lewmv_pkg and lewmv_cell.
module lewmv_window (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        command_i,
  input  logic [lewmv_pkg::ERR_W-1:0] error_count_i,
  input  logic [lewmv_pkg::LVL_W-1:0] mcs_level_i,
  output logic                        s1_valid_o,
  input  logic                        s1_ready_i,
  output lewmv_pkg::sum_t             s1_o
);
  import lewmv_pkg::*;

  logic [ERR_W-1:0] tap [WINDOW_LEN];
  logic             acc, shift;

  logic [CNT_W-1:0]    count_q, count_d, pos;
  logic                full_q, full_d, wrap;
  logic [WHOLE_W-1:0]  whole_q, whole_d;
  logic [RECENT_W-1:0] newest_q, newest_d;
  logic [ERR_W-1:0]    old_whole, old_recent;
  logic                s1_valid_q;
  sum_t                s1_q;

  assign in_ready_o = !s1_valid_q || s1_ready_i;
  assign acc        = in_valid_i && in_ready_o;
  assign shift      = acc && (command_i == CMD_SAMPLE);

  for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
    if (i == 0) begin : g_head
      lewmv_cell u_cell (
        .clk_i  (clk_i),
        .shift_i(shift),
        .data_i (error_count_i),
        .data_o (tap[i])
      );
    end else begin : g_body
      lewmv_cell u_cell (
        .clk_i  (clk_i),
        .shift_i(shift),
        .data_i (tap[i-1]),
        .data_o (tap[i])
      );
    end
  end

  always_comb begin
    wrap       = (count_q == CNT_W'(WINDOW_LEN));
    pos        = wrap ? '0 : count_q;
    old_whole  = (full_q || wrap) ? tap[WINDOW_LEN-1] : '0;
    old_recent = (full_q || wrap || (pos >= CNT_W'(RECENT_LEN))) ? tap[RECENT_LEN-1] : '0;
    if (command_i == CMD_RESTART) begin
      count_d  = '0;
      full_d   = 1'b0;
      whole_d  = '0;
      newest_d = '0;
    end else begin
      count_d  = pos + CNT_W'(1);
      full_d   = full_q || wrap;
      whole_d  = whole_q - WHOLE_W'(old_whole) + WHOLE_W'(error_count_i);
      newest_d = newest_q - RECENT_W'(old_recent) + RECENT_W'(error_count_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      full_q     <= 1'b0;
      whole_q    <= '0;
      newest_q   <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (acc) begin
        count_q  <= count_d;
        full_q   <= full_d;
        whole_q  <= whole_d;
        newest_q <= newest_d;
      end
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_q.full   <= full_d;
      s1_q.level  <= mcs_level_i;
      s1_q.whole  <= whole_d;
      s1_q.newest <= newest_d;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_o       = s1_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(WINDOW_LEN))
    else $error("fill count beyond window");

  a_recent_le_whole: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WHOLE_W'(newest_q) <= whole_q)
    else $error("recent sum exceeds whole sum");

  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && (command_i == CMD_RESTART) |=> count_q == '0 && !full_q && whole_q == '0
      && newest_q == '0)
    else $error("restart did not clear window state");

  a_full_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q && !(acc && (command_i == CMD_RESTART)) |=> full_q)
    else $error("full flag dropped without restart");

endmodule

// ===== rtl/lewmv_vote.sv =====
// Percentages and step vote from the running sums, with the output register.
// Depends on lewmv_pkg.
module lewmv_vote (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s1_valid_i,
  output logic                           s1_ready_o,
  input  lewmv_pkg::sum_t                s1_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           window_full_o,
  output logic [1:0]                     vote_o,
  output logic [lewmv_pkg::WHOLE_W-1:0]  total_errors_o,
  output logic [lewmv_pkg::RECENT_W-1:0] recent_errors_o,
  output logic [lewmv_pkg::PCT_W-1:0]    total_percent_o,
  output logic [lewmv_pkg::PCT_W-1:0]    recent_percent_o
);
  import lewmv_pkg::*;

  logic              out_valid_q;
  logic              full_q;
  vote_e             vote_q, vote_d;
  logic [WHOLE_W-1:0]  whole_q;
  logic [RECENT_W-1:0] newest_q;
  logic [PCT_W-1:0]  tpct_q, tpct_d, rpct_q, rpct_d;

  assign s1_ready_o = !out_valid_q || out_ready_i;

  always_comb begin
    case (s1_i.level)
      3'd0, 3'd1: begin
        tpct_d = s1_i.whole[15:6];
        rpct_d = s1_i.newest[14:5];
      end
      3'd2: begin
        tpct_d = PCT_W'(s1_i.whole[15:7]);
        rpct_d = PCT_W'(s1_i.newest[14:6]);
      end
      3'd3: begin
        tpct_d = PCT_W'(s1_i.whole[15:8]);
        rpct_d = PCT_W'(s1_i.newest[14:7]);
      end
      3'd4, 3'd5: begin
        tpct_d = div3(s1_i.whole[15:7]);
        rpct_d = div3(s1_i.newest[14:6]);
      end
      default: begin
        tpct_d = '0;
        rpct_d = '0;
      end
    endcase
  end

  always_comb begin
    vote_d = VOTE_KEEP;
    if (s1_i.full) begin
      if (up_ok(s1_i.level) && (s1_i.whole <= up_limit(s1_i.level))) begin
        vote_d = VOTE_UP;
      end
      if (down_ok(s1_i.level) && (s1_i.newest >= down_limit(s1_i.level))) begin
        vote_d = VOTE_DOWN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_ready_o) begin
      out_valid_q <= s1_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_i && s1_ready_o) begin
      full_q   <= s1_i.full;
      vote_q   <= vote_d;
      whole_q  <= s1_i.whole;
      newest_q <= s1_i.newest;
      tpct_q   <= tpct_d;
      rpct_q   <= rpct_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign window_full_o    = full_q;
  assign vote_o           = vote_q;
  assign total_errors_o   = whole_q;
  assign recent_errors_o  = newest_q;
  assign total_percent_o  = tpct_q;
  assign recent_percent_o = rpct_q;

  a_vote_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !full_q |-> vote_q == VOTE_KEEP)
    else $error("vote given before window full");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(whole_q) && $stable(vote_q))
    else $error("stalled result changed");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_i && s1_ready_o && (s1_i.level == 3'd6 || s1_i.level == 3'd7)
      |=> tpct_q == '0 && rpct_q == '0 && vote_q == VOTE_KEEP)
    else $error("invalid level produced a percentage or vote");

endmodule

// ===== rtl/ldpc_error_window_mcs_vote.sv =====
// LDPC error window with modulation step vote: one result word per input word.
// Path: window register, then output register; one word per cycle unless out_ready_i is low.
// The rate is set by the running-sum update in lewmv_window (one row shift per sample word).
// A restart word clears fill count, full flag and sums; cell contents are kept.
// Reset (rst_ni low, asynchronous) clears control state and sums; no clearing pass.
// Depends on lewmv_pkg, lewmv_window, lewmv_vote.
module ldpc_error_window_mcs_vote (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           command_i,
  input  logic [lewmv_pkg::ERR_W-1:0]    error_count_i,
  input  logic [lewmv_pkg::LVL_W-1:0]    mcs_level_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           window_full_o,
  output logic [1:0]                     vote_o,
  output logic [lewmv_pkg::WHOLE_W-1:0]  total_errors_o,
  output logic [lewmv_pkg::RECENT_W-1:0] recent_errors_o,
  output logic [lewmv_pkg::PCT_W-1:0]    total_percent_o,
  output logic [lewmv_pkg::PCT_W-1:0]    recent_percent_o
);
  import lewmv_pkg::*;

  logic s1_valid, s1_ready;
  sum_t s1;

  lewmv_window u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .error_count_i(error_count_i),
    .mcs_level_i  (mcs_level_i),
    .s1_valid_o   (s1_valid),
    .s1_ready_i   (s1_ready),
    .s1_o         (s1)
  );

  lewmv_vote u_vote (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s1_valid_i      (s1_valid),
    .s1_ready_o      (s1_ready),
    .s1_i            (s1),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .window_full_o   (window_full_o),
    .vote_o          (vote_o),
    .total_errors_o  (total_errors_o),
    .recent_errors_o (recent_errors_o),
    .total_percent_o (total_percent_o),
    .recent_percent_o(recent_percent_o)
  );

endmodule

// ===== tb/tb_ldpc_error_window_mcs_vote.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for ldpc_error_window_mcs_vote: a scoreboard class predicts
// every result word from the accepted input words; a task drives the input channel, an always block the receiver.
// Depends on lewmv_pkg and the block RTL.
module tb_ldpc_error_window_mcs_vote;
  import lewmv_pkg::*;

  localparam int RAND_WORDS  = 900;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 20;

  typedef enum logic [2:0] {
    PH_FREE,
    PH_SRC_IDLE,
    PH_SINK_STALL,
    PH_BOTH,
    PH_PRESSURE,
    PH_DRAIN
  } phase_e;

  typedef struct packed {
    logic                full;
    logic [1:0]          vote;
    logic [WHOLE_W-1:0]  total;
    logic [RECENT_W-1:0] recent;
    logic [PCT_W-1:0]    tpct;
    logic [PCT_W-1:0]    rpct;
  } window_result_t;

  class window_scoreboard;
    bit [ERR_W-1:0] err_ring [WINDOW_LEN];
    int unsigned    wr_pos;
    bit             ring_full;
    int unsigned    whole_sum;
    int unsigned    newest_sum;
    window_result_t pending [$];
    int             fails;
    int             words_in;
    int             results;
    int             ups;
    int             downs;
    int             full_seen;

    function int unsigned level_total(input logic [LVL_W-1:0] lvl);
      case (lvl)
        3'd0, 3'd1: return 32 * 200;
        3'd2:       return 64 * 200;
        3'd3:       return 128 * 200;
        default:    return 192 * 200;
      endcase
    endfunction

    function void note_word(input cmd_e cmd, input logic [ERR_W-1:0] err,
                            input logic [LVL_W-1:0] lvl);
      window_result_t r;
      int unsigned pos, rpos, old_whole, old_newest, lt;
      r = '0;
      words_in++;
      if (cmd == CMD_RESTART) begin
        wr_pos     = 0;
        ring_full  = 1'b0;
        whole_sum  = 0;
        newest_sum = 0;
      end else begin
        if (wr_pos >= WINDOW_LEN) begin
          wr_pos    = 0;
          ring_full = 1'b1;
        end
        pos        = wr_pos;
        rpos       = (pos + WINDOW_LEN - RECENT_LEN) % WINDOW_LEN;
        old_whole  = ring_full ? err_ring[pos] : 0;
        old_newest = (ring_full || pos >= RECENT_LEN) ? err_ring[rpos] : 0;
        err_ring[pos] = err;
        wr_pos        = pos + 1;
        whole_sum     = whole_sum - old_whole + err;
        newest_sum    = newest_sum - old_newest + err;
        r.full   = ring_full;
        r.total  = WHOLE_W'(whole_sum);
        r.recent = RECENT_W'(newest_sum);
        r.vote   = VOTE_KEEP;
        if (lvl <= 3'd5) begin
          lt     = level_total(lvl);
          r.tpct = PCT_W'((whole_sum * 100) / lt);
          r.rpct = PCT_W'((newest_sum * 200) / lt);
          if (ring_full) begin
            case (lvl)
              3'd1: if (whole_sum <= 960)  r.vote = VOTE_UP;
              3'd2: if (whole_sum <= 1280) r.vote = VOTE_UP;
              3'd3: if (whole_sum <= 1280) r.vote = VOTE_UP;
              3'd4: if (whole_sum <= 5)    r.vote = VOTE_UP;
              default: ;
            endcase
            case (lvl)
              3'd1: if (newest_sum >= 2240) r.vote = VOTE_DOWN;
              3'd2: if (newest_sum >= 2880) r.vote = VOTE_DOWN;
              3'd3: if (newest_sum >= 5120) r.vote = VOTE_DOWN;
              3'd4: if (newest_sum >= 5760) r.vote = VOTE_DOWN;
              3'd5: if (newest_sum >= 4800) r.vote = VOTE_DOWN;
              default: ;
            endcase
          end
        end
      end
      pending.push_back(r);
    endfunction

    function void cmp_field(input string name, input int unsigned exp_v,
                            input int unsigned act_v);
      if (exp_v != act_v) begin
        fails++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(input window_result_t got);
      window_result_t exp_r;
      results++;
      if (pending.size() == 0) begin
        fails++;
        $display("%0t: unexpected result word, expected none actual total %0d",
                 $time, got.total);
        return;
      end
      exp_r = pending.pop_front();
      cmp_field("window_full", exp_r.full, got.full);
      cmp_field("vote", exp_r.vote, got.vote);
      cmp_field("total_errors", exp_r.total, got.total);
      cmp_field("recent_errors", exp_r.recent, got.recent);
      cmp_field("total_percent", exp_r.tpct, got.tpct);
      cmp_field("recent_percent", exp_r.rpct, got.rpct);
      if (exp_r.full) full_seen++;
      if (exp_r.vote == VOTE_UP) ups++;
      if (exp_r.vote == VOTE_DOWN) downs++;
    endfunction
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                in_valid_i    = 1'b0;
  logic                in_ready_o;
  logic                command_i     = 1'b0;
  logic [ERR_W-1:0]    error_count_i = '0;
  logic [LVL_W-1:0]    mcs_level_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i   = 1'b0;
  logic                window_full_o;
  logic [1:0]          vote_o;
  logic [WHOLE_W-1:0]  total_errors_o;
  logic [RECENT_W-1:0] recent_errors_o;
  logic [PCT_W-1:0]    total_percent_o;
  logic [PCT_W-1:0]    recent_percent_o;

  phase_e           phase         = PH_FREE;
  logic             pressure_done = 1'b0;
  int               hold_count    = 0;
  window_scoreboard sb            = new();

  ldpc_error_window_mcs_vote uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .command_i        (command_i),
    .error_count_i    (error_count_i),
    .mcs_level_i      (mcs_level_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .window_full_o    (window_full_o),
    .vote_o           (vote_o),
    .total_errors_o   (total_errors_o),
    .recent_errors_o  (recent_errors_o),
    .total_percent_o  (total_percent_o),
    .recent_percent_o (recent_percent_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic int src_idle_pct(input phase_e ph);
    case (ph)
      PH_SRC_IDLE: return 64;
      PH_BOTH:     return 33;
      default:     return 0;
    endcase
  endfunction

  function automatic int sink_stall_pct(input phase_e ph);
    case (ph)
      PH_SINK_STALL: return 64;
      PH_BOTH:       return 33;
      default:       return 0;
    endcase
  endfunction

  // receiver; long hold-off once in the pressure phase
  always @(posedge clk_i) begin
    if (phase == PH_PRESSURE && !pressure_done) begin
      out_ready_i <= 1'b0;
      hold_count  <= hold_count + 1;
      if (hold_count == HOLD_CYCLES) pressure_done <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= sink_stall_pct(phase));
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result('{window_full_o, vote_o, total_errors_o, recent_errors_o,
                        total_percent_o, recent_percent_o});
    end
  end

  task automatic send_word(input cmd_e cmd, input logic [ERR_W-1:0] err,
                           input logic [LVL_W-1:0] lvl);
    while ($urandom_range(0, 99) < src_idle_pct(phase)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    error_count_i <= err;
    mcs_level_i   <= lvl;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_word(cmd, err, lvl);
  endtask

  function automatic logic [ERR_W-1:0] pick_err(input int regime);
    case (regime)
      0:       return ($urandom_range(0, 49) == 0) ? 8'd1 : 8'd0;
      1:       return ERR_W'($urandom_range(0, 9));
      2:       return ERR_W'($urandom_range(0, 60));
      3:       return ERR_W'($urandom_range(0, 255));
      default: return ($urandom_range(0, 3) == 0) ? ERR_W'($urandom) : ERR_W'($urandom_range(0, 5));
    endcase
  endfunction

  initial begin
    int          sent;
    int          seg_len;
    int          regime;
    bit          lvl_hop;
    logic [2:0]  seg_lvl;
    logic [2:0]  lvl;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: restarts, extremes of count and level, out-of-range levels
    send_word(CMD_RESTART, 8'd255, 3'd7);
    for (int l = 0; l < 8; l++) send_word(CMD_SAMPLE, 8'd255, 3'(l));
    send_word(CMD_SAMPLE, 8'd0, 3'd7);
    send_word(CMD_SAMPLE, 8'd1, 3'd4);
    send_word(CMD_SAMPLE, 8'd0, 3'd0);
    send_word(CMD_RESTART, 8'd0, 3'd0);
    send_word(CMD_SAMPLE, 8'd170, 3'd5);
    send_word(CMD_SAMPLE, 8'd85, 3'd2);
    send_word(CMD_SAMPLE, 8'd255, 3'd6);
    send_word(CMD_RESTART, 8'd170, 3'd5);

    // random: sample runs of 150 to 430 words, often long enough to fill and wrap the window, then a restart
    sent = 0;
    while (sent < RAND_WORDS) begin
      seg_len = $urandom_range(150, 430);
      regime  = $urandom_range(0, 4);
      lvl_hop = ($urandom_range(0, 4) == 0);
      seg_lvl = 3'($urandom_range(0, 5));
      for (int i = 0; i < seg_len && sent < RAND_WORDS; i++) begin
        phase <= phase_e'((sent * 5) / RAND_WORDS);
        lvl = lvl_hop ? 3'($urandom_range(0, 7)) : seg_lvl;
        if ($urandom_range(0, 299) == 0)
          send_word(CMD_RESTART, ERR_W'($urandom), 3'($urandom));
        else
          send_word(CMD_SAMPLE, pick_err(regime), lvl);
        sent++;
      end
      send_word(CMD_RESTART, ERR_W'($urandom), 3'($urandom));
      sent++;
    end

    in_valid_i <= 1'b0;
    phase      <= PH_DRAIN;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Run covered %0d input words and %0d result words, %0d with a full window.",
             sb.words_in, sb.results, sb.full_seen);
    $display("Votes predicted: %0d step up, %0d step down.", sb.ups, sb.downs);
    if (sb.fails == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0t: %0d mismatches, %0d results never arrived", $time, sb.fails,
               sb.pending.size());
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("%0t: timeout, %0d results still expected", $time, sb.pending.size());
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/lewmv_pkg.sv
rtl/lewmv_cell.sv
rtl/lewmv_window.sv
rtl/lewmv_vote.sv
rtl/ldpc_error_window_mcs_vote.sv
tb/tb_ldpc_error_window_mcs_vote.sv
